>>> src/gicd_pkg.sv
// Shared types and constants for the gamepad input change detector.
// Used by the divider, the axis history store and the top level.
`default_nettype none
package gicd_pkg;

  localparam int PAD_SLOTS    = 8;
  localparam int BUTTON_COUNT = 21;
  localparam int AXIS_COUNT   = 6;

  localparam int SLOT_W  = 3;
  localparam int INDEX_W = 5;
  localparam int RAW_W   = 16;
  localparam int CFG_W   = 15;

  localparam int AXIS_ENTRIES = PAD_SLOTS * AXIS_COUNT;
  localparam int POS_W        = (AXIS_ENTRIES > 1) ? $clog2(AXIS_ENTRIES) : 1;

  localparam int Q_W       = 15;
  localparam int NUM_W     = 2 * Q_W;
  localparam int DIV_STEPS = Q_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  localparam logic [Q_W-1:0]   FULL_SCALE      = 15'd32767;
  localparam logic [CFG_W-1:0] DEAD_ZONE_RESET = 15'd8000;
  localparam logic [CFG_W-1:0] THRESHOLD_RESET = 15'd1638;

  localparam logic [1:0] REG_DEAD_ZONE = 2'd0;
  localparam logic [1:0] REG_THRESHOLD = 2'd1;

  localparam logic EV_BUTTON = 1'b0;
  localparam logic EV_AXIS   = 1'b1;

  typedef enum logic [1:0] {
    KIND_BUTTON = 2'd0,
    KIND_AXIS   = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_BUTTON,
    S_MULT,
    S_PREP,
    S_DIV,
    S_SIGN,
    S_EVAL,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   den;
  } div_req_t;

  typedef struct packed {
    logic              rd_en;
    logic [POS_W-1:0]  rd_addr;
    logic              wr_en;
    logic [POS_W-1:0]  wr_addr;
    logic [RAW_W-1:0]  wr_data;
    logic              clr_en;
    logic [SLOT_W-1:0] clr_slot;
  } store_req_t;

endpackage
`default_nettype wire

>>> src/gicd_divider.sv
// Restoring divider, one quotient bit per cycle, for the axis rescale.
// Depends on gicd_pkg; the caller keeps the quotient below 2**Q_W.
`default_nettype none
module gicd_divider (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire gicd_pkg::div_req_t  req,
  output logic                     done,
  output logic [gicd_pkg::Q_W-1:0] quotient
);
  import gicd_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] count;
  logic [Q_W-1:0]   rem;
  logic [Q_W-1:0]   den;
  logic [Q_W:0]     partial;
  logic [Q_W+1:0]   trial;
  logic             ge;

  assign partial = {rem, quotient[Q_W-1]};
  assign trial   = {1'b0, partial} - {2'b00, den};
  assign ge      = !trial[Q_W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + 1'b1;
        if (count == CNT_W'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= req.num[NUM_W-1:Q_W];
      quotient <= req.num[Q_W-1:0];
      den      <= req.den;
    end else if (busy) begin
      rem      <= ge ? trial[Q_W-1:0] : partial[Q_W-1:0];
      quotient <= {quotient[Q_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

>>> src/gicd_axis_store.sv
// Last reported axis value for every slot and axis, one entry per pair.
// Depends on gicd_pkg; entries without a valid bit read as zero.
`default_nettype none
module gicd_axis_store (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire gicd_pkg::store_req_t  req,
  output logic [gicd_pkg::RAW_W-1:0] rd_data
);
  import gicd_pkg::*;

  logic [RAW_W-1:0]        mem [AXIS_ENTRIES];
  logic [AXIS_ENTRIES-1:0] valid;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= valid[req.rd_addr] ? mem[req.rd_addr] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (req.wr_en) begin
        valid[req.wr_addr] <= 1'b1;
      end
      if (req.clr_en) begin
        for (int a = 0; a < AXIS_COUNT; a++) begin
          valid[POS_W'(int'(req.clr_slot) * AXIS_COUNT + a)] <= 1'b0;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> src/gamepad_input_change_detector_unit.sv
// Gamepad input change detector: sequencer, history and output beat register.
// Depends on gicd_pkg, gicd_divider and gicd_axis_store.
// Axis item: scaled by the 15-step serial divider, which is skipped in the dead zone or saturated.
// Button, clear and ignored items bypass the divider. One item at a time.
// An event waits in the emit state while the previous beat waits in the output register.
// Reset (rst, synchronous): histories zero, dead_zone 8000, emit_threshold 1638.
`default_nettype none
module gamepad_input_change_detector_unit (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [1:0]              kind,
  input  wire logic [2:0]              pad_slot,
  input  wire logic [4:0]              control_index,
  input  wire logic signed [15:0]      axis_raw,
  input  wire logic                    button_level,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic                         event_kind,
  output logic [2:0]                   event_slot,
  output logic [4:0]                   event_index,
  output logic                         pressed,
  output logic signed [15:0]           axis_value,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [1:0]              cfg_index,
  input  wire logic [14:0]             cfg_data
);
  import gicd_pkg::*;

  state_t state, state_next;

  logic [CFG_W-1:0] dead_zone;
  logic [CFG_W-1:0] emit_threshold;

  logic [BUTTON_COUNT-1:0] button_hist [PAD_SLOTS];

  logic               item_kind_axis;
  logic [SLOT_W-1:0]  item_slot;
  logic [INDEX_W-1:0] item_idx;
  logic [RAW_W-1:0]   item_raw;
  logic               item_level;
  logic [POS_W-1:0]   item_pos;

  logic             neg;
  logic             below;
  logic             full;
  logic [NUM_W-1:0] num;
  logic [Q_W-1:0]   q;
  logic signed [RAW_W-1:0] value;

  logic accept;
  logic slot_ok;
  logic out_free;
  logic emit_go;
  logic btn_changed;
  logic axis_emit;
  logic sat;
  logic [Q_W-1:0]   den;
  logic [RAW_W-1:0] mag;
  logic [RAW_W-1:0] mag_off;
  logic [POS_W-1:0] in_pos;
  logic signed [RAW_W-1:0] prev;
  logic signed [RAW_W:0]   diff;
  logic [RAW_W:0]          diff_abs;

  div_req_t         div_req;
  logic             div_done;
  logic [Q_W-1:0]   div_q;
  store_req_t       store_req;
  logic [RAW_W-1:0] store_rd;

  gicd_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  gicd_axis_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (store_req),
    .rd_data (store_rd)
  );

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;
  assign slot_ok   = int'(pad_slot) < PAD_SLOTS;
  assign in_pos    = POS_W'(int'(pad_slot) * AXIS_COUNT + int'(control_index));
  assign out_free  = !out_valid || out_ready;

  assign den     = FULL_SCALE - dead_zone;
  assign mag     = item_raw[RAW_W-1] ? RAW_W'(-item_raw) : item_raw;
  assign mag_off = mag - {1'b0, dead_zone};
  assign sat     = num >= {den, {Q_W{1'b0}}};

  assign btn_changed = button_hist[item_slot][item_idx] != item_level;

  assign prev      = signed'(store_rd);
  assign diff      = {value[RAW_W-1], value} - {prev[RAW_W-1], prev};
  assign diff_abs  = diff[RAW_W] ? -diff : diff;
  assign axis_emit = ((prev == '0) != (value == '0)) ||
                     (diff_abs >= {2'b00, emit_threshold});

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && slot_ok) begin
          case (kind_t'(kind))
            KIND_BUTTON: if (int'(control_index) < BUTTON_COUNT) state_next = S_BUTTON;
            KIND_AXIS:   if (int'(control_index) < AXIS_COUNT) state_next = S_MULT;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_BUTTON: state_next = btn_changed ? S_EMIT : S_IDLE;
      S_MULT:   state_next = S_PREP;
      S_PREP:   state_next = (below || full || sat) ? S_SIGN : S_DIV;
      S_DIV:    if (div_done) state_next = S_SIGN;
      S_SIGN:   state_next = S_EVAL;
      S_EVAL:   state_next = axis_emit ? S_EMIT : S_IDLE;
      S_EMIT:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready           = 1'b0;
    emit_go            = 1'b0;
    div_req.start      = 1'b0;
    div_req.num        = num;
    div_req.den        = den;
    store_req.rd_en    = 1'b0;
    store_req.rd_addr  = in_pos;
    store_req.wr_en    = 1'b0;
    store_req.wr_addr  = item_pos;
    store_req.wr_data  = value;
    store_req.clr_en   = 1'b0;
    store_req.clr_slot = pad_slot;
    case (state)
      S_IDLE: begin
        in_ready           = 1'b1;
        store_req.rd_en    = accept;
        store_req.clr_en   = accept && slot_ok && (kind_t'(kind) == KIND_CLEAR);
      end
      S_PREP:  div_req.start   = !(below || full || sat);
      S_EVAL:  store_req.wr_en = axis_emit;
      S_EMIT:  emit_go         = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      dead_zone      <= DEAD_ZONE_RESET;
      emit_threshold <= THRESHOLD_RESET;
      out_valid      <= 1'b0;
      for (int s = 0; s < PAD_SLOTS; s++) begin
        button_hist[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEAD_ZONE: dead_zone      <= cfg_data;
          REG_THRESHOLD: emit_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (store_req.clr_en) begin
        button_hist[pad_slot] <= '0;
      end else if (state == S_BUTTON && btn_changed) begin
        button_hist[item_slot][item_idx] <= item_level;
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_kind_axis <= kind_t'(kind) == KIND_AXIS;
      item_slot      <= pad_slot;
      item_idx       <= control_index;
      item_raw       <= axis_raw;
      item_level     <= button_level;
      item_pos       <= in_pos;
    end
    case (state)
      S_MULT: begin
        neg   <= item_raw[RAW_W-1];
        below <= mag < {1'b0, dead_zone};
        full  <= dead_zone == FULL_SCALE;
        num   <= NUM_W'(mag_off) * NUM_W'(FULL_SCALE);
      end
      S_PREP: begin
        q <= below ? '0 : FULL_SCALE;
      end
      S_DIV: begin
        if (div_done) q <= div_q;
      end
      S_SIGN: begin
        value <= neg ? -signed'({1'b0, q}) : signed'({1'b0, q});
      end
      default: ;
    endcase
    if (emit_go) begin
      event_kind  <= item_kind_axis ? EV_AXIS : EV_BUTTON;
      event_slot  <= item_slot;
      event_index <= item_idx;
      pressed     <= item_kind_axis ? 1'b0 : item_level;
      axis_value  <= item_kind_axis ? value : '0;
    end
  end

endmodule
`default_nettype wire

>>> dv/gamepad_input_change_detector_unit_tb.sv
// Self-checking testbench for gamepad_input_change_detector_unit: a directed table,
// then random samples over several register settings, each checked against a predictor.
// Depends on gicd_pkg and the gamepad_input_change_detector_unit RTL.
`timescale 1ns / 100ps
module gamepad_input_change_detector_unit_tb;
  import gicd_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;
  localparam int PHASES      = 10;
  localparam int PHASE_ITEMS = 115;
  localparam int SETTLE      = 32;
  localparam int CYCLE_LIMIT = 400000;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_NO_EVENT,
    ROW_EVENT
  } row_mode_t;

  typedef struct packed {
    logic               ev_kind;
    logic [2:0]         slot;
    logic [4:0]         ctl;
    logic               pressed;
    logic signed [15:0] value;
  } pad_event_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         slot;
    logic [4:0]         idx;
    logic signed [15:0] raw;
    logic               lvl;
    row_mode_t          mode;
    pad_event_t         ev;
  } sample_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [1:0]         kind = '0;
  logic [2:0]         pad_slot = '0;
  logic [4:0]         control_index = '0;
  logic signed [15:0] axis_raw = '0;
  logic               button_level = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               event_kind;
  logic [2:0]         event_slot;
  logic [4:0]         event_index;
  logic               pressed;
  logic signed [15:0] axis_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [14:0]        cfg_data = '0;

  // predictor state
  logic [BUTTON_COUNT-1:0] btn_levels [PAD_SLOTS];
  logic signed [15:0]      axis_last  [AXIS_ENTRIES];
  logic [14:0]             dz_now  = DEAD_ZONE_RESET;
  logic [14:0]             thr_now = THRESHOLD_RESET;

  pad_event_t         events_due [$];
  sample_row_t        row_now = '0;
  logic signed [15:0] last_raw [AXIS_ENTRIES];
  int  src_idle = 11;
  int  sink_idle = 47;
  bit  input_low = 1'b1;
  int  fails = 0;
  int  items_sent = 0;
  int  beats_seen = 0;
  int  cfg_writes = 0;
  int  cycles = 0;

  gamepad_input_change_detector_unit u_top (
    .clk, .rst, .in_valid, .in_ready, .kind, .pad_slot, .control_index, .axis_raw,
    .button_level, .out_valid, .out_ready, .event_kind, .event_slot, .event_index,
    .pressed, .axis_value, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    for (int s = 0; s < PAD_SLOTS; s++) btn_levels[s] = '0;
    for (int p = 0; p < AXIS_ENTRIES; p++) begin
      axis_last[p] = '0;
      last_raw[p] = '0;
    end
  end

  function automatic logic signed [15:0] deadband_scale(input logic signed [15:0] raw);
    int mag;
    int dz;
    int q;
    dz = int'(dz_now);
    mag = (raw < 0) ? -int'(raw) : int'(raw);
    if (mag < dz) return '0;
    if (dz >= int'(FULL_SCALE)) begin
      q = int'(FULL_SCALE);
    end else begin
      q = ((mag - dz) * int'(FULL_SCALE)) / (int'(FULL_SCALE) - dz);
      if (q > int'(FULL_SCALE)) q = int'(FULL_SCALE);
    end
    return (raw < 0) ? 16'(-q) : 16'(q);
  endfunction

  function automatic bit detect_change(input sample_row_t r, output pad_event_t ev);
    int pos;
    int diff;
    bit crossed;
    logic signed [15:0] q;
    ev = '0;
    ev.slot = r.slot;
    ev.ctl = r.idx;
    case (r.kind)
      KIND_BUTTON: begin
        if (r.idx >= BUTTON_COUNT) return 1'b0;
        if (btn_levels[r.slot][r.idx] == r.lvl) return 1'b0;
        btn_levels[r.slot][r.idx] = r.lvl;
        ev.ev_kind = EV_BUTTON;
        ev.pressed = r.lvl;
        return 1'b1;
      end
      KIND_AXIS: begin
        if (r.idx >= AXIS_COUNT) return 1'b0;
        pos = r.slot * AXIS_COUNT + r.idx;
        q = deadband_scale(r.raw);
        crossed = (axis_last[pos] == 0) != (q == 0);
        diff = int'(q) - int'(axis_last[pos]);
        if (diff < 0) diff = -diff;
        if (!crossed && diff < int'(thr_now)) return 1'b0;
        axis_last[pos] = q;
        ev.ev_kind = EV_AXIS;
        ev.value = q;
        return 1'b1;
      end
      KIND_CLEAR: begin
        btn_levels[r.slot] = '0;
        for (int a = 0; a < AXIS_COUNT; a++) axis_last[r.slot * AXIS_COUNT + a] = '0;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic sample_row_t mk_row(input logic [1:0] k, input int s, input int i,
                                         input int raw, input logic lvl,
                                         input row_mode_t m, input int val);
    sample_row_t r;
    r.kind = k;
    r.slot = 3'(s);
    r.idx = 5'(i);
    r.raw = 16'(raw);
    r.lvl = lvl;
    r.mode = m;
    r.ev.ev_kind = (k == KIND_BUTTON) ? EV_BUTTON : EV_AXIS;
    r.ev.slot = 3'(s);
    r.ev.ctl = 5'(i);
    r.ev.pressed = (k == KIND_BUTTON) ? lvl : 1'b0;
    r.ev.value = 16'(val);
    return r;
  endfunction

  // mostly well-formed samples; a share of clears, bad indexes and the unused kind
  function automatic sample_row_t rand_sample(output bit counts);
    int roll;
    int sub;
    int s;
    int i;
    int pos;
    int mag;
    int span;
    logic signed [15:0] raw;
    roll = $urandom_range(0, 99);
    s = $urandom_range(0, PAD_SLOTS - 1);
    raw = 16'($urandom);
    counts = (roll < 82);
    if (roll < 30) return mk_row(KIND_BUTTON, s, $urandom_range(0, BUTTON_COUNT - 1), raw,
                                 1'($urandom), ROW_PREDICT, 0);
    if (roll < 78) begin
      i = $urandom_range(0, AXIS_COUNT - 1);
      pos = s * AXIS_COUNT + i;
      sub = $urandom_range(0, 99);
      if (sub < 20) begin
        mag = int'(dz_now) + $urandom_range(0, 40) - 20;
        if (mag < 0) mag = 0;
        if (mag > 32767) mag = 32767;
        raw = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      end else if (sub < 32) begin
        case ($urandom_range(0, 4))
          0: raw = 16'sd32767;
          1: raw = -16'sd32768;
          2: raw = -16'sd32767;
          3: raw = 16'sd0;
          default: raw = -16'sd1;
        endcase
      end else if (sub >= 50) begin
        span = 2 * int'(thr_now) + 64;
        raw = 16'(int'(last_raw[pos]) + $urandom_range(0, span) - span / 2);
      end
      last_raw[pos] = raw;
      return mk_row(KIND_AXIS, s, i, raw, 1'($urandom), ROW_PREDICT, 0);
    end
    if (roll < 82) return mk_row(KIND_CLEAR, s, $urandom_range(0, 31), raw, 1'($urandom),
                                 ROW_PREDICT, 0);
    if (roll < 87) return mk_row(KIND_BUTTON, s, $urandom_range(BUTTON_COUNT, 31), raw,
                                 1'($urandom), ROW_PREDICT, 0);
    if (roll < 92) return mk_row(KIND_AXIS, s, $urandom_range(AXIS_COUNT, 31), raw,
                                 1'($urandom), ROW_PREDICT, 0);
    return mk_row(KIND_UNUSED, s, $urandom_range(0, 31), raw, 1'($urandom), ROW_PREDICT, 0);
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    pad_event_t e;
    pad_event_t ev;
    bit fired;
    if (!rst) begin
      if (out_valid && out_ready) begin
        beats_seen++;
        if (events_due.size() == 0) begin
          $error("event beat with none pending: slot %0d index %0d", event_slot, event_index);
          fails++;
        end else begin
          e = events_due.pop_front();
          check_field("event_kind", e.ev_kind, event_kind);
          check_field("event_slot", e.slot, event_slot);
          check_field("event_index", e.ctl, event_index);
          check_field("pressed", e.pressed, pressed);
          check_field("axis_value", int'(e.value), int'(axis_value));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_DEAD_ZONE: dz_now = cfg_data;
          REG_THRESHOLD: thr_now = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        fired = detect_change(row_now, ev);
        if (row_now.mode == ROW_EVENT) events_due = {events_due, row_now.ev};
        else if (row_now.mode == ROW_PREDICT && fired) events_due = {events_due, ev};
      end
    end
  end

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic send(input sample_row_t r);
    int gap;
    kind <= r.kind;
    pad_slot <= r.slot;
    control_index <= r.idx;
    axis_raw <= r.raw;
    button_level <= r.lvl;
    row_now <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
    gap = 0;
    if ($urandom_range(0, 99) < src_idle) gap = $urandom_range(1, 4);
    input_low = (gap > 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic stop_input();
    if (!input_low) in_valid <= 1'b0;
    input_low = 1'b1;
  endtask

  task automatic wait_quiet();
    @(posedge clk);
    while (events_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input int data);
    cfg_index <= idx;
    cfg_data <= 15'(data);
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  initial begin : stimulus
    sample_row_t plan [$];
    sample_row_t r;
    int dz_plan [PHASES];
    int thr_plan [PHASES];
    int counted;
    bit counts;
    dz_plan  = '{8000, 0, 32767, 32766, 1, 0, 0, 30000, 4, 8000};
    thr_plan = '{1638, 0, 32767, 1, 32767, 0, 0, 0, 16384, 1638};
    for (int p = 5; p <= 6; p++) begin
      dz_plan[p] = $urandom_range(0, 32767);
      thr_plan[p] = $urandom_range(0, 32767);
    end
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: dead zone 8000, threshold 1638
    plan = {plan, mk_row(KIND_BUTTON, 0, 0, 0, 1'b1, ROW_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 0, 0, 0, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 7, 20, -1, 1'b1, ROW_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 7, 20, 0, 1'b0, ROW_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 3, 21, 0, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 3, 31, 0, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 0, 0, 32767, 1'b1, ROW_EVENT, 32767)};
    plan = {plan, mk_row(KIND_AXIS, 0, 0, -32768, 1'b0, ROW_EVENT, -32767)};
    plan = {plan, mk_row(KIND_AXIS, 0, 0, 7999, 1'b0, ROW_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 0, 0, -7999, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 7, 5, 8000, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 7, 5, 20000, 1'b0, ROW_PREDICT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 7, 5, 20100, 1'b0, ROW_PREDICT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 7, 5, -20100, 1'b0, ROW_PREDICT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 1, 6, 32767, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 1, 31, -1, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_UNUSED, 2, 0, 32767, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 4, 2, 32767, 1'b0, ROW_EVENT, 32767)};
    plan = {plan, mk_row(KIND_CLEAR, 0, 31, -1, 1'b1, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 0, 0, 0, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_BUTTON, 0, 0, 0, 1'b1, ROW_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 0, 0, -1, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_CLEAR, 7, 0, 0, 1'b0, ROW_NO_EVENT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 7, 5, 9000, 1'b0, ROW_PREDICT, 0)};
    plan = {plan, mk_row(KIND_AXIS, 4, 2, 32767, 1'b0, ROW_NO_EVENT, 0)};
    foreach (plan[n]) send(plan[n]);

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        stop_input();
        wait_quiet();
        cfg_write(REG_DEAD_ZONE, dz_plan[p]);
        cfg_write(REG_THRESHOLD, thr_plan[p]);
        if (p == 2) begin
          cfg_write(REG_SPARE_A, $urandom);
          cfg_write(REG_SPARE_B, $urandom);
        end
      end
      if (p <= 3) begin
        src_idle = 11;
        sink_idle = 47;
      end else if (p <= 6) begin
        src_idle = 47;
        sink_idle = 11;
      end else begin
        src_idle = 0;
        sink_idle = 0;
      end
      counted = 0;
      while (counted < PHASE_ITEMS) begin
        r = rand_sample(counts);
        send(r);
        if (counts) counted++;
      end
    end

    stop_input();
    wait_quiet();
    $display("%0d samples sent under %0d register settings (%0d register writes)",
             items_sent, PHASES, cfg_writes);
    $display("%0d change events compared, %0d field mismatches", beats_seen, fails);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> gamepad_input_change_detector_unit.f
src/gicd_pkg.sv
src/gicd_divider.sv
src/gicd_axis_store.sv
src/gamepad_input_change_detector_unit.sv
dv/gamepad_input_change_detector_unit_tb.sv
